[src/csp_pkg.sv]
// Shared types and constants for the textured wall column span block.
// Depends on nothing; every other file of the block imports it.
package csp_pkg;

  // Screen and fixed-point geometry.
  localparam int unsigned SCREEN_HEIGHT = 1024;
  localparam int unsigned HALF_W        = 17;
  localparam logic [HALF_W-1:0] HALF_SCREEN = HALF_W'(SCREEN_HEIGHT / 2);

  localparam int unsigned ROW_W    = 12;
  localparam int unsigned TROWS_W  = 13;
  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned STEP_W   = 29;
  localparam int unsigned POS_W    = 46;
  localparam int unsigned MAG_W    = 16;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PITCH_W  = 16;
  localparam int unsigned BPT_W    = 4;
  localparam int unsigned CNT_W    = 5;

  localparam int unsigned DIV_STEPS = STEP_W;
  localparam int unsigned MUL_STEPS = MAG_W;

  localparam logic [TROWS_W-1:0] MAX_TROWS = TROWS_W'(4096);

  // Configuration port.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_PITCH       = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_BYTES_PER_TEXEL = CFG_INDEX_W'(1);
  localparam logic [PITCH_W-1:0] ROW_PITCH_RESET = PITCH_W'(256);
  localparam logic [BPT_W-1:0]   BPT_RESET       = BPT_W'(4);

  // Input item kinds.
  localparam logic KIND_COLUMN = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [ROW_W-1:0]    column_x;
    logic [ROW_W-1:0]    span_top;
    logic [ROW_W-1:0]    span_bottom;
    logic [HEIGHT_W-1:0] wall_height;
    logic [TROWS_W-1:0]  texture_rows;
    logic [ROW_W-1:0]    texture_column;
    logic [ADDR_W-1:0]   texture_base;
    logic                wall_side;
  } csp_in_t;

  typedef struct packed {
    logic [ROW_W-1:0]  pixel_x;
    logic [ROW_W-1:0]  pixel_y;
    logic [ADDR_W-1:0] texel_address;
    logic              darken;
    logic              last_pixel;
  } csp_out_t;

  // Request to the divide/multiply unit for one column.
  typedef struct packed {
    logic [TROWS_W-1:0]  rows;
    logic [HEIGHT_W-1:0] height;
    logic [MAG_W-1:0]    mag;
    logic                neg;
  } csp_arith_req_t;

  // Request to the texel address stage for one pixel.
  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [TROWS_W-1:0] rows;
    logic [ROW_W-1:0]   column;
    logic [ADDR_W-1:0]  base;
  } csp_texel_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COLUMN,
    ST_EMIT
  } csp_state_t;

  typedef enum logic [2:0] {
    AR_IDLE,
    AR_DIV,
    AR_MUL,
    AR_NEG,
    AR_DONE
  } csp_arith_phase_t;

endpackage

[src/textured_wall_column_span.sv]
// Top level of the textured wall column span block: sequencer, span state,
// configuration registers and output register.
// Depends on csp_pkg, csp_div_mul and csp_texel_addr.
//
//   channel  signals                          payload
//   in       in_valid / in_ready              in_item (csp_in_t)
//   out      out_valid / out_ready            out_item (csp_out_t)
//   cfg      cfg_valid / cfg_ready            cfg_index, cfg_data
//
// For a column item the step is found by a 29-step restoring
// division and the start position by a 16-step shift-add multiply, both on
// the one shared adder of csp_div_mul, followed by a negate and a handoff step.
// For a pixel item the row clamp and column offset are registered, then the address
// add goes into the output register; a pixel item with no active span is dropped.
// A held output item only delays the address add. Synchronous reset
// returns the span to inactive and the registers to pitch 256, texel size 4.
module textured_wall_column_span (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  csp_pkg::csp_in_t                    in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output csp_pkg::csp_out_t                   out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [csp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [csp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import csp_pkg::*;

  csp_state_t state, state_next;

  logic [PITCH_W-1:0]  row_pitch_bytes;
  logic [BPT_W-1:0]    bytes_per_texel;

  logic                span_active;
  logic [ROW_W-1:0]    current_row;
  logic [ROW_W-1:0]    end_row;
  logic [STEP_W-1:0]   step_size;
  logic [POS_W-1:0]    texture_position;
  logic [ROW_W-1:0]    saved_column;
  logic [ADDR_W-1:0]   saved_base;
  logic [ROW_W-1:0]    saved_tex_column;
  logic [TROWS_W-1:0]  saved_rows;
  logic                saved_side;

  logic [ROW_W-1:0]    pend_y;
  logic                pend_last;

  logic                take_in, take_column, take_pixel, out_free;
  logic [HEIGHT_W-1:0] height_sat;
  logic [TROWS_W-1:0]  rows_sat;
  logic [HALF_W-1:0]   centre_sum;
  csp_arith_req_t      arith_req;
  logic                arith_done;
  logic [STEP_W-1:0]   arith_step;
  logic [POS_W-1:0]    arith_pos;
  csp_texel_req_t      texel_req;
  logic [ADDR_W-1:0]   texel_address;
  logic                is_last;

  assign take_in     = in_valid & in_ready;
  assign take_column = take_in & (in_item.kind == KIND_COLUMN);
  assign take_pixel  = take_in & (in_item.kind == KIND_PIXEL) & span_active;
  assign out_free    = ~out_valid | out_ready;
  assign cfg_ready   = 1'b1;
  assign is_last     = (current_row == end_row);

  // Column setup: saturate height and rows, split the centre offset into sign
  // and magnitude for the multiply.
  always_comb begin
    height_sat = (in_item.wall_height == '0) ? HEIGHT_W'(1) : in_item.wall_height;
    if (in_item.texture_rows == '0) begin
      rows_sat = TROWS_W'(1);
    end else if (in_item.texture_rows > MAX_TROWS) begin
      rows_sat = MAX_TROWS;
    end else begin
      rows_sat = in_item.texture_rows;
    end
    centre_sum       = HALF_W'(in_item.span_top) + HALF_W'(height_sat[HEIGHT_W-1:1]);
    arith_req.rows   = rows_sat;
    arith_req.height = height_sat;
    arith_req.neg    = (centre_sum < HALF_SCREEN);
    if (centre_sum < HALF_SCREEN) begin
      arith_req.mag = MAG_W'(HALF_SCREEN - centre_sum);
    end else begin
      arith_req.mag = MAG_W'(centre_sum - HALF_SCREEN);
    end
  end

  csp_div_mul u_div_mul (
    .clk       (clk),
    .rst       (rst),
    .start     (take_column),
    .req       (arith_req),
    .done      (arith_done),
    .step_size (arith_step),
    .position  (arith_pos)
  );

  assign texel_req.position = texture_position;
  assign texel_req.rows     = saved_rows;
  assign texel_req.column   = saved_tex_column;
  assign texel_req.base     = saved_base;

  csp_texel_addr u_texel_addr (
    .clk             (clk),
    .load            (take_pixel),
    .req             (texel_req),
    .row_pitch_bytes (row_pitch_bytes),
    .bytes_per_texel (bytes_per_texel),
    .texel_address   (texel_address)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take_column) begin
          state_next = ST_COLUMN;
        end else if (take_pixel) begin
          state_next = ST_EMIT;
        end
      end
      ST_COLUMN: if (arith_done) state_next = ST_IDLE;
      ST_EMIT:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs of the sequencer.
  always_comb begin
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pitch_bytes <= ROW_PITCH_RESET;
      bytes_per_texel <= BPT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROW_PITCH:       row_pitch_bytes <= cfg_data;
        CFG_BYTES_PER_TEXEL: bytes_per_texel <= cfg_data[BPT_W-1:0];
        default: ;
      endcase
    end
  end

  // Span state: loaded by a column item, walked by pixel items.
  always_ff @(posedge clk) begin
    if (rst) begin
      span_active      <= 1'b0;
      current_row      <= '0;
      end_row          <= '0;
      step_size        <= '0;
      texture_position <= '0;
    end else begin
      if (take_column) begin
        current_row <= in_item.span_top;
        end_row     <= in_item.span_bottom;
        span_active <= (in_item.span_top <= in_item.span_bottom);
      end else if (take_pixel) begin
        texture_position <= texture_position + POS_W'(step_size);
        if (is_last) begin
          span_active <= 1'b0;
        end else begin
          current_row <= current_row + ROW_W'(1);
        end
      end
      if (state == ST_COLUMN && arith_done) begin
        step_size        <= arith_step;
        texture_position <= arith_pos;
      end
    end
  end

  // Texture selection and the row of the pixel under way.
  always_ff @(posedge clk) begin
    if (take_column) begin
      saved_column     <= in_item.column_x;
      saved_base       <= in_item.texture_base;
      saved_tex_column <= in_item.texture_column;
      saved_rows       <= rows_sat;
      saved_side       <= in_item.wall_side;
    end
    if (take_pixel) begin
      pend_y    <= current_row;
      pend_last <= is_last;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      out_item.pixel_x       <= saved_column;
      out_item.pixel_y       <= pend_y;
      out_item.texel_address <= texel_address;
      out_item.darken        <= saved_side;
      out_item.last_pixel    <= pend_last;
    end
  end

endmodule

[src/csp_div_mul.sv]
// Iterative divide and multiply unit around one shared 46-bit adder.
// Computes the Q13.16 step and the signed start position of a column.
// Depends on csp_pkg.
module csp_div_mul (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  csp_pkg::csp_arith_req_t         req,
  output logic                            done,
  output logic [csp_pkg::STEP_W-1:0]      step_size,
  output logic [csp_pkg::POS_W-1:0]       position
);
  import csp_pkg::*;

  csp_arith_phase_t phase, phase_next;

  logic [CNT_W-1:0]    count;
  logic [HEIGHT_W-1:0] rem;
  logic [STEP_W-1:0]   quo;
  logic [HEIGHT_W-1:0] divisor;
  logic [MAG_W-1:0]    mult;
  logic [POS_W-1:0]    mcand;
  logic [POS_W-1:0]    acc;
  logic                neg;

  logic [POS_W-1:0]    add_a, add_b, add_sum;
  logic                add_sub;
  logic [HEIGHT_W:0]   rem_shift;
  logic                ge;
  logic [STEP_W-1:0]   quo_shift;
  logic                div_last, mul_last;

  // Shared adder: a + b or a - b.
  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + POS_W'(add_sub);

  assign rem_shift = {rem, quo[STEP_W-1]};
  assign ge        = ~add_sum[POS_W-1];
  assign quo_shift = {quo[STEP_W-2:0], ge};
  assign div_last  = (count == CNT_W'(DIV_STEPS - 1));
  assign mul_last  = (count == CNT_W'(MUL_STEPS - 1));

  // Next phase.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      AR_IDLE: if (start) phase_next = AR_DIV;
      AR_DIV:  if (div_last) phase_next = AR_MUL;
      AR_MUL:  if (mul_last) phase_next = AR_NEG;
      AR_NEG:  phase_next = AR_DONE;
      AR_DONE: phase_next = AR_IDLE;
      default: phase_next = AR_IDLE;
    endcase
  end

  // Adder operands and status for each phase.
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    done    = 1'b0;
    unique case (phase)
      AR_DIV: begin
        add_a   = POS_W'(rem_shift);
        add_b   = POS_W'(divisor);
        add_sub = 1'b1;
      end
      AR_MUL: begin
        add_a = acc;
        add_b = mult[0] ? mcand : '0;
      end
      AR_NEG: begin
        add_b   = acc;
        add_sub = 1'b1;
      end
      AR_DONE: done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= AR_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  // Datapath registers, one step per cycle.
  always_ff @(posedge clk) begin
    case (phase)
      AR_IDLE: begin
        if (start) begin
          quo     <= {req.rows, FRAC_W'(0)};
          rem     <= '0;
          divisor <= req.height;
          mult    <= req.mag;
          neg     <= req.neg;
          count   <= '0;
        end
      end
      AR_DIV: begin
        rem   <= ge ? add_sum[HEIGHT_W-1:0] : rem_shift[HEIGHT_W-1:0];
        quo   <= quo_shift;
        count <= div_last ? '0 : count + CNT_W'(1);
        if (div_last) begin
          acc   <= '0;
          mcand <= POS_W'(quo_shift);
        end
      end
      AR_MUL: begin
        acc   <= add_sum;
        mcand <= {mcand[POS_W-2:0], 1'b0};
        mult  <= {1'b0, mult[MAG_W-1:1]};
        count <= count + CNT_W'(1);
      end
      AR_NEG: begin
        if (neg) acc <= add_sum;
      end
      default: ;
    endcase
  end

  assign step_size = quo;
  assign position  = acc;

endmodule

[src/csp_texel_addr.sv]
// Texel address stage: clamps the texture row and forms the byte address.
// Registers the row and column offset, then adds base, row offset and column offset.
// Depends on csp_pkg.
module csp_texel_addr (
  input  logic                          clk,
  input  logic                          load,
  input  csp_pkg::csp_texel_req_t       req,
  input  logic [csp_pkg::PITCH_W-1:0]   row_pitch_bytes,
  input  logic [csp_pkg::BPT_W-1:0]     bytes_per_texel,
  output logic [csp_pkg::ADDR_W-1:0]    texel_address
);
  import csp_pkg::*;

  localparam int unsigned WHOLE_W = POS_W - FRAC_W;
  localparam int unsigned ROWP_W  = ROW_W + PITCH_W;
  localparam int unsigned COLP_W  = ROW_W + BPT_W;

  logic [WHOLE_W-1:0] whole;
  logic [TROWS_W-1:0] rows_m1;
  logic [ROW_W-1:0]   trow_calc;

  logic [ROW_W-1:0]   trow;
  logic [COLP_W-1:0]  col_offset;
  logic [ADDR_W-1:0]  base;
  logic [ROWP_W-1:0]  row_offset;

  // Texture row: negative positions give row zero, large ones the last row.
  assign whole   = req.position[POS_W-1:FRAC_W];
  assign rows_m1 = req.rows - TROWS_W'(1);
  always_comb begin
    if (req.position[POS_W-1]) begin
      trow_calc = '0;
    end else if (whole >= WHOLE_W'(req.rows)) begin
      trow_calc = rows_m1[ROW_W-1:0];
    end else begin
      trow_calc = whole[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      trow       <= trow_calc;
      col_offset <= COLP_W'(req.column) * COLP_W'(bytes_per_texel);
      base       <= req.base;
    end
  end

  // Final address, wrapping at 32 bits.
  assign row_offset    = ROWP_W'(trow) * ROWP_W'(row_pitch_bytes);
  assign texel_address = base + ADDR_W'(row_offset) + ADDR_W'(col_offset);

endmodule
